/* sv/id_to_prefix_lookup_table_unit_defines.svh */
// Assertion macros for the id-to-prefix lookup table unit.
// Used by id_to_prefix_lookup_table_unit.sv; expects clk and rst in scope.
`ifndef ID_TO_PREFIX_LOOKUP_TABLE_UNIT_DEFINES_SVH
`define ID_TO_PREFIX_LOOKUP_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IPLT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define IPLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define IPLT_ASSERT_ALWAYS(label, expr, msg)
`define IPLT_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

/* sv/iplt_pkg.sv */
// Shared types and constants for the id-to-prefix lookup table unit.
// No dependencies.
package iplt_pkg;

  localparam int KEY_W = 128;
  localparam int VAL_W = 128;
  localparam int HALF_W = 64;
  localparam int STATUS_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              op;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic [HALF_W-1:0] value_high;
    logic [HALF_W-1:0] value_low;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HALF_W-1:0]   found_high;
    logic [HALF_W-1:0]   found_low;
  } rsp_t;

  // search token walking the cell chain
  typedef struct packed {
    logic             valid;
    logic             op;
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } tok_t;

  // append write broadcast to all cells
  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wr_t;

endpackage

/* sv/iplt_cell.sv */
// One table entry of the lookup chain: holds a key/value pair, compares the
// passing token and registers it toward the next cell. Depends on iplt_pkg.
module iplt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic [CW-1:0]   count,
  input  iplt_pkg::wr_t   wr,
  input  iplt_pkg::tok_t  tok_in,
  output iplt_pkg::tok_t  tok_out
);
  import iplt_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic             filled;
  logic             match;
  tok_t             tok_next;

  assign filled = IDX_C < count;
  assign match  = tok_in.valid && !tok_in.hit && filled && (tok_in.key == key);

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit = 1'b1;
      if (tok_in.op == OP_LOOKUP) begin
        tok_next.value = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && (count == IDX_C)) begin
      key   <= wr.key;
      value <= wr.value;
    end else if (adv && match && (tok_in.op == OP_INSERT)) begin
      value <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

/* sv/id_to_prefix_lookup_table_unit.sv */
// A request transfer loads the head token, which walks the chain of TABLE_DEPTH
// entry cells one cell per cycle while the chain is not stalled; one item in
// flight, so a new request is taken only after the previous token leaves the chain.
// A waiting response does not block the next request; the chain stalls only
// if a new result meets a full output register.
// Reset (rst, synchronous) clears the entry count and control; entries are not cleared.
`include "id_to_prefix_lookup_table_unit_defines.svh"

module id_to_prefix_lookup_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  iplt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output iplt_pkg::rsp_t rsp
);
  import iplt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  tok_t                 chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0] tok_vld;
  tok_t                 head;
  tok_t                 exit_tok;
  wr_t                  wr;
  logic [CW-1:0]        entry_count;
  logic                 busy;
  logic                 adv;
  logic                 req_xfer;
  logic                 done;
  logic                 not_full;
  rsp_t                 rsp_next;

  assign req_ready = !busy;
  assign req_xfer  = req_valid && req_ready;
  assign exit_tok  = chain[TABLE_DEPTH];
  assign adv       = !(exit_tok.valid && rsp_valid && !rsp_ready);
  assign done      = adv && exit_tok.valid;
  assign not_full  = entry_count < DEPTH_C;

  assign chain[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    iplt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .count   (entry_count),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_vld
    assign tok_vld[i] = chain[i].valid;
  end

  always_comb begin
    wr.we    = done && (exit_tok.op == OP_INSERT) && !exit_tok.hit && not_full;
    wr.key   = exit_tok.key;
    wr.value = exit_tok.value;
  end

  always_comb begin
    rsp_next = '0;
    if (exit_tok.op == OP_LOOKUP) begin
      if (exit_tok.hit) begin
        rsp_next.status     = ST_HIT;
        rsp_next.found_high = exit_tok.value[VAL_W-1:HALF_W];
        rsp_next.found_low  = exit_tok.value[HALF_W-1:0];
      end else begin
        rsp_next.status = ST_MISS;
      end
    end else if (exit_tok.hit) begin
      rsp_next.status = ST_UPDATED;
    end else if (not_full) begin
      rsp_next.status = ST_APPENDED;
    end else begin
      rsp_next.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (req_xfer) begin
      head.valid <= 1'b1;
      head.op    <= req.op;
      head.hit   <= 1'b0;
      head.key   <= {req.key_high, req.key_low};
      head.value <= {req.value_high, req.value_low};
    end else if (adv) begin
      head.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_xfer) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr.we) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= rsp_next;
    end
  end

  `IPLT_ASSERT_ALWAYS(a_count_bound, entry_count <= DEPTH_C, "entry count above depth")
  `IPLT_ASSERT_ALWAYS(a_one_token, $countones(tok_vld) <= 1, "more than one token in chain")
  `IPLT_ASSERT_IMPL(a_idle_empty, !busy, tok_vld == '0, "token in chain while idle")
  `IPLT_ASSERT_IMPL(a_full_status, rsp_valid && rsp.status == ST_FULL, entry_count == DEPTH_C, "full status below depth")
  `IPLT_ASSERT_IMPL(a_zero_on_nohit, rsp_valid && rsp.status != ST_HIT, rsp.found_high == '0 && rsp.found_low == '0, "nonzero prefix without hit")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for id_to_prefix_lookup_table_unit: a table model
// predicts insert/lookup status and found prefix per request transfer.
// Depends on iplt_pkg and the unit RTL only.
`timescale 1ns / 1ps

module testbench;
  import iplt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES = 400;

  class prefix_table_scoreboard;
    logic [KEY_W-1:0] entry_key [TABLE_DEPTH];
    logic [VAL_W-1:0] entry_val [TABLE_DEPTH];
    int unsigned      fill = 0;
    rsp_t             awaited[$];
    int unsigned      errors = 0;
    int unsigned      status_tally [5];

    function void note_request(req_t r);
      logic [KEY_W-1:0] k;
      int unsigned      slot;
      rsp_t             res;
      k = {r.key_high, r.key_low};
      slot = fill;
      for (int i = 0; i < fill; i++) begin
        if (slot == fill && entry_key[i] == k) begin
          slot = i;
        end
      end
      res = '0;
      if (r.op == OP_LOOKUP) begin
        if (slot < fill) begin
          res.status = ST_HIT;
          {res.found_high, res.found_low} = entry_val[slot];
        end else begin
          res.status = ST_MISS;
        end
      end else if (slot < fill) begin
        entry_val[slot] = {r.value_high, r.value_low};
        res.status = ST_UPDATED;
      end else if (fill < TABLE_DEPTH) begin
        entry_key[fill] = k;
        entry_val[fill] = {r.value_high, r.value_low};
        fill++;
        res.status = ST_APPENDED;
      end else begin
        res.status = ST_FULL;
      end
      status_tally[res.status]++;
      awaited.push_back(res);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $error("unexpected response transfer: status %0d", got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found_high !== want.found_high) begin
        $error("found_high: expected %h, got %h", want.found_high, got.found_high);
        errors++;
      end
      if (got.found_low !== want.found_low) begin
        $error("found_low: expected %h, got %h", want.found_low, got.found_low);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rsp_hold_cycles = 0;
  logic [KEY_W-1:0] known_keys[$];
  prefix_table_scoreboard lookup_model = new();

  id_to_prefix_lookup_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] rand_word128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic req_t make_req(input logic op, input logic [KEY_W-1:0] k,
                                    input logic [VAL_W-1:0] v);
    req_t r;
    r.op = op;
    {r.key_high, r.key_low} = k;
    {r.value_high, r.value_low} = v;
    return r;
  endfunction

  // mostly known keys, some single-bit near misses, some fresh keys
  function automatic req_t random_request();
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
    end else if (pick < 80) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      k[$urandom_range(KEY_W - 1)] ^= 1'b1;
    end else begin
      k = rand_word128();
    end
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: v = rand_word128();
    endcase
    return make_req(($urandom_range(99) < 55) ? OP_LOOKUP : OP_INSERT, k, v);
  endfunction

  task automatic send_request(input req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    lookup_model.note_request(r);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
        lookup_model.check_response(rsp);
      end
      if (rsp_hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 54;
    send_request(make_req(OP_LOOKUP, '0, '1));
    send_request(make_req(OP_INSERT, '0, '1));
    send_request(make_req(OP_INSERT, '1, '0));
    send_request(make_req(OP_LOOKUP, '0, '0));
    send_request(make_req(OP_LOOKUP, '1, '1));
    send_request(make_req(OP_INSERT, '0, {2{64'h5555_aaaa_5555_aaaa}}));
    send_request(make_req(OP_LOOKUP, '0, '0));
    send_request(make_req(OP_LOOKUP, 128'h1, '0));
    send_request(make_req(OP_LOOKUP, {1'b0, {127{1'b1}}}, '0));
    known_keys.push_back('0);
    known_keys.push_back('1);
    while (known_keys.size() < TABLE_DEPTH) begin
      k = rand_word128();
      known_keys.push_back(k);
      send_request(make_req(OP_INSERT, k, rand_word128()));
    end
    // table is full now: new key dropped, existing key still updated
    k = rand_word128();
    send_request(make_req(OP_INSERT, k, rand_word128()));
    send_request(make_req(OP_LOOKUP, k, '0));
    send_request(make_req(OP_INSERT, '1, rand_word128()));
    send_request(make_req(OP_LOOKUP, known_keys[TABLE_DEPTH - 1], '0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          rsp_hold_cycles = HOLD_CYCLES;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) send_request(random_request());
    end
    req_valid <= 1'b0;

    while (lookup_model.awaited.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);

    $display("covered: %0d hits, %0d misses, %0d appends, %0d updates, %0d full-table drops",
             lookup_model.status_tally[ST_HIT], lookup_model.status_tally[ST_MISS],
             lookup_model.status_tally[ST_APPENDED], lookup_model.status_tally[ST_UPDATED],
             lookup_model.status_tally[ST_FULL]);
    $display("idle mixes on both sides plus a %0d-cycle response backpressure stretch",
             HOLD_CYCLES);
    if (lookup_model.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
